// ----- rtl/pfq_pkg.sv -----
package pfq_pkg;

    // command codes of the input channel
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

    // field widths
    localparam int POS_W   = 19;
    localparam int VTX_W   = 20;
    localparam int LIFE_W  = 18;
    localparam int SIZE_W  = 11;
    localparam int COLOR_W = 8;
    localparam int TIME_W  = 16;

    // lowest lifetime a particle can hold
    localparam logic signed [LIFE_W:0] LIFE_FLOOR = -19'sd131072;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // input transfer: latch delta time, clear walk index
        logic add;        // append a particle unless full
        logic pop;        // drop the front particle
        logic walk_step;  // age one particle, advance index
        logic load;       // fetch particle at index, set up divider
        logic div_step;   // one quotient bit
        logic emit;       // load one vertex into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic front_expired;
        logic walk_done;
        logic div_last;
        logic out_free;
        logic corner_last;
        logic part_last;
    } t_dp_status;

endpackage

// ----- rtl/pfq_ctrl.sv -----
module pfq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [pfq_pkg::CMD_W-1:0]    i_command,
    output logic                         o_stall,
    input  pfq_pkg::t_dp_status          i_status,
    output pfq_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POP  = 6'b000010,
        S_WALK = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_command)
                        pfq_pkg::CMD_ADD:  o_cmd.add = 1'b1;
                        pfq_pkg::CMD_TICK: n_state = S_POP;
                        pfq_pkg::CMD_DRAW: begin
                            if (!i_status.count_zero) n_state = S_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                if (i_status.front_expired) o_cmd.pop = 1'b1;
                else n_state = S_WALK;
            end
            S_WALK: begin
                if (i_status.walk_done) n_state = S_IDLE;
                else o_cmd.walk_step = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.corner_last) begin
                        n_state = i_status.part_last ? S_IDLE : S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/pfq_datapath.sv -----
module pfq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pfq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pfq_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [pfq_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [pfq_pkg::POS_W-1:0]       i_pos_y,
    input  logic [pfq_pkg::TIME_W-1:0]             i_delta_time,
    input  pfq_pkg::t_dp_cmd                       i_cmd,
    output pfq_pkg::t_dp_status                    o_status,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic signed [pfq_pkg::VTX_W-1:0]       o_vertex_x,
    output logic signed [pfq_pkg::VTX_W-1:0]       o_vertex_y,
    output logic [pfq_pkg::SIZE_W-1:0]             o_tex_u,
    output logic [pfq_pkg::SIZE_W-1:0]             o_tex_v,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_red,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_green,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_blue,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_alpha,
    output logic                                   o_last_vertex
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
    localparam int LW  = pfq_pkg::LIFE_W;
    localparam int PW  = pfq_pkg::POS_W;
    localparam int VW  = pfq_pkg::VTX_W;
    localparam int SW  = pfq_pkg::SIZE_W;
    localparam int CLW = pfq_pkg::COLOR_W;
    localparam int TW  = pfq_pkg::TIME_W;
    // remainder holds 255 * positive life (life below 2^(LW-1))
    localparam int RW  = LW - 1 + 8;

    // ring position of an offset from a base slot
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= DEPTH_EXT) sum = sum - DEPTH_EXT;
        return sum[IW-1:0];
    endfunction

    // configuration registers
    logic [TW-1:0]  r_lifetime;
    logic [CLW-1:0] r_red;
    logic [CLW-1:0] r_green;
    logic [CLW-1:0] r_blue;
    logic [SW-1:0]  r_width;
    logic [SW-1:0]  r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= TW'(1000);
            r_red      <= 8'd255;
            r_green    <= 8'd255;
            r_blue     <= 8'd255;
            r_width    <= SW'(16);
            r_height   <= SW'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfq_pkg::CFG_LIFETIME: r_lifetime <= i_cfg_data[TW-1:0];
                pfq_pkg::CFG_RED:      r_red      <= i_cfg_data[CLW-1:0];
                pfq_pkg::CFG_GREEN:    r_green    <= i_cfg_data[CLW-1:0];
                pfq_pkg::CFG_BLUE:     r_blue     <= i_cfg_data[CLW-1:0];
                pfq_pkg::CFG_WIDTH:    r_width    <= i_cfg_data[SW-1:0];
                pfq_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // particle slots
    logic signed [PW-1:0] r_slot_x     [QUEUE_DEPTH];
    logic signed [PW-1:0] r_slot_y     [QUEUE_DEPTH];
    logic signed [LW-1:0] r_slot_life  [QUEUE_DEPTH];
    logic [3*CLW-1:0]     r_slot_color [QUEUE_DEPTH];

    // queue control
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [1:0]    r_corner;
    logic [2:0]    r_div_k;
    logic          r_valid;

    logic [IW-1:0]        rd_slot;
    logic [IW-1:0]        wr_slot;
    logic [IW-1:0]        head_next;
    logic signed [LW-1:0] rd_life;
    logic                 add_ok;
    logic signed [LW:0]   aged;
    logic signed [LW:0]   aged_clamped;
    logic [CW:0]          idx_inc;

    assign rd_slot   = f_slot(r_head, r_idx);
    assign wr_slot   = f_slot(r_head, r_count);
    assign head_next = f_slot(r_head, CW'(1));
    assign rd_life   = r_slot_life[rd_slot];
    assign add_ok    = i_cmd.add && (r_count < DEPTH_CNT);
    assign idx_inc   = (CW + 1)'(r_idx) + (CW + 1)'(1);

    // aging with floor clamp
    logic [TW-1:0] r_dt;
    always_comb begin
        aged = {rd_life[LW-1], rd_life} - (LW + 1)'(r_dt);
        aged_clamped = (aged < pfq_pkg::LIFE_FLOOR) ? pfq_pkg::LIFE_FLOOR : aged;
    end

    // slot writes
    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            r_slot_x[wr_slot]     <= i_pos_x;
            r_slot_y[wr_slot]     <= i_pos_y;
            r_slot_color[wr_slot] <= {r_red, r_green, r_blue};
        end
        if (add_ok) begin
            r_slot_life[wr_slot] <= LW'(r_lifetime);
        end else if (i_cmd.walk_step) begin
            r_slot_life[rd_slot] <= aged_clamped[LW-1:0];
        end
    end

    // head, count, index, corner and divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_corner <= '0;
            r_div_k  <= '0;
        end else begin
            if (add_ok) r_count <= r_count + CW'(1);
            if (i_cmd.pop) begin
                r_head  <= head_next;
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.accept) r_idx <= '0;
            if (i_cmd.walk_step) r_idx <= idx_inc[CW-1:0];
            if (i_cmd.load) begin
                r_corner <= '0;
                r_div_k  <= 3'd7;
            end
            if (i_cmd.div_step) r_div_k <= r_div_k - 3'd1;
            if (i_cmd.emit) begin
                r_corner <= r_corner + 2'd1;
                if (r_corner == 2'd3) r_idx <= idx_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_dt <= i_delta_time;
    end

    // particle latch and alpha divider
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic [3*CLW-1:0]     r_pcolor;
    logic                 r_live;
    logic                 r_sat;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_dsh;
    logic [7:0]           r_quo;
    logic [RW-1:0]        scaled;

    assign scaled = {rd_life[LW-2:0], 8'b0} - RW'(rd_life[LW-2:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= r_slot_x[rd_slot];
            r_py     <= r_slot_y[rd_slot];
            r_pcolor <= r_slot_color[rd_slot];
            r_live   <= (rd_life > 0);
            r_sat    <= (scaled >= RW'({r_lifetime, 8'b0}));
            r_rem    <= scaled;
            r_dsh    <= RW'({r_lifetime, 7'b0});
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_quo <= {r_quo[6:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    // vertex corner select
    logic signed [VW-1:0] half_w;
    logic signed [VW-1:0] half_h;
    logic signed [VW-1:0] ext_x;
    logic signed [VW-1:0] ext_y;
    logic                 right;
    logic                 bottom;
    logic [CLW-1:0]       alpha;

    assign half_w = VW'({r_width, 3'b0});
    assign half_h = VW'({r_height, 3'b0});
    assign ext_x  = VW'(r_px);
    assign ext_y  = VW'(r_py);
    assign right  = (r_corner == 2'd1) || (r_corner == 2'd2);
    assign bottom = r_corner[1];
    assign alpha  = !r_live ? 8'd0 : (r_sat ? 8'd255 : r_quo);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_vertex_x    <= right ? (ext_x + half_w) : (ext_x - half_w);
            o_vertex_y    <= bottom ? (ext_y + half_h) : (ext_y - half_h);
            o_tex_u       <= right ? r_width : '0;
            o_tex_v       <= bottom ? r_height : '0;
            o_out_red     <= r_pcolor[3*CLW-1:2*CLW];
            o_out_green   <= r_pcolor[2*CLW-1:CLW];
            o_out_blue    <= r_pcolor[CLW-1:0];
            o_out_alpha   <= alpha;
            o_last_vertex <= (r_corner == 2'd3) && (idx_inc == (CW + 1)'(r_count));
        end
    end

    assign o_valid = r_valid;

    // status to controller
    always_comb begin
        o_status.count_zero    = (r_count == '0);
        o_status.front_expired = (r_count != '0) && (rd_life <= 0);
        o_status.walk_done     = (r_idx == r_count);
        o_status.div_last      = (r_div_k == 3'd0);
        o_status.out_free      = !r_valid || !i_stall;
        o_status.corner_last   = (r_corner == 2'd3);
        o_status.part_last     = (idx_inc == (CW + 1)'(r_count));
    end

endmodule

// ----- rtl/particle_fade_queue.sv -----
// Particle queue with lifetime fade. Holds up to QUEUE_DEPTH particles in
// arrival order. An add transfer drops the particle when the queue is full.
// A tick accepts the transfer, pops each expired particle from the front,
// finds the first live particle, takes one aging step per particle left and
// then finds the end of the walk. The slot store is walked one entry a cycle
// through its single read address.
// A draw accepts the transfer, then for each particle fetches it, runs the
// bit-serial alpha divider (one quotient bit a cycle) and makes four vertex
// transfers, which wait while the output is stalled. The output register
// lets the next command be accepted while the final vertex still waits.
// Configuration writes are meant for idle time.
module particle_fade_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pfq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pfq_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [pfq_pkg::CMD_W-1:0]              i_command,
    input  logic signed [pfq_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [pfq_pkg::POS_W-1:0]       i_pos_y,
    input  logic [pfq_pkg::TIME_W-1:0]             i_delta_time,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pfq_pkg::VTX_W-1:0]       o_vertex_x,
    output logic signed [pfq_pkg::VTX_W-1:0]       o_vertex_y,
    output logic [pfq_pkg::SIZE_W-1:0]             o_tex_u,
    output logic [pfq_pkg::SIZE_W-1:0]             o_tex_v,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_red,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_green,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_blue,
    output logic [pfq_pkg::COLOR_W-1:0]            o_out_alpha,
    output logic                                   o_last_vertex
);

    pfq_pkg::t_dp_cmd    dp_cmd;
    pfq_pkg::t_dp_status dp_status;

    // sequencer
    pfq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    // slots, divider and output register
    pfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_delta_time  (i_delta_time),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_last_vertex (o_last_vertex)
    );

endmodule
